@@ rtl/segint_pkg.sv @@
// Package for the segment intersection block.
// Holds the coordinate widths, the derived datapath widths and the divider stage record.
// Depends on nothing; every other file in rtl uses it.
package segint_pkg;

   localparam int COORD_BITS = 16;
   localparam int CALC_BITS  = (COORD_BITS > 20) ? 20 : COORD_BITS;

   // Differences of two coordinates.
   localparam int DIFF_BITS  = CALC_BITS + 1;
   // Products of two differences.
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   // Denominator and numerators, signed.
   localparam int NUM_BITS   = PROD_BITS + 1;
   // Magnitude of a positive denominator or numerator.
   localparam int MAG_BITS   = NUM_BITS - 1;
   // Quotient magnitude bits, which are also the number of divider steps.
   localparam int QUO_BITS   = DIFF_BITS;
   // Dividend magnitude: numerator magnitude times coordinate span.
   localparam int DVD_BITS   = MAG_BITS + DIFF_BITS;

   typedef struct packed {
      logic                        valid;
      logic                        hit;
      logic                        neg_x;
      logic                        neg_y;
      logic signed [CALC_BITS-1:0] ax0;
      logic signed [CALC_BITS-1:0] ay0;
      logic [MAG_BITS-1:0]         den;
      logic [MAG_BITS-1:0]         rem_x;
      logic [MAG_BITS-1:0]         rem_y;
      logic [QUO_BITS-1:0]         low_x;
      logic [QUO_BITS-1:0]         low_y;
      logic [QUO_BITS-1:0]         quo_x;
      logic [QUO_BITS-1:0]         quo_y;
   } div_type;

endpackage

@@ rtl/segint_front.sv @@
// Front end of the segment intersection pipeline: differences, products,
// cross terms, hit test and dividend multiply in four register stages.
// Depends on segint_pkg; feeds the first divider step.
module segint_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     advance,
   input  logic                                     in_valid,
   input  logic signed [segint_pkg::COORD_BITS-1:0] a_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] a_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] a_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] a_end_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] b_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] b_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] b_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] b_end_y,
   output segint_pkg::div_type                      out
);
   import segint_pkg::*;

   logic signed [CALC_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

   logic                        v1_ff;
   logic signed [DIFF_BITS-1:0] dax_ff, day_ff, dbx_ff, dby_ff, sx_ff, sy_ff;
   logic signed [CALC_BITS-1:0] ax0_1_ff, ay0_1_ff;

   logic                        v2_ff;
   logic signed [PROD_BITS-1:0] p_den1_ff, p_den2_ff, p_tn1_ff, p_tn2_ff, p_un1_ff, p_un2_ff;
   logic signed [CALC_BITS-1:0] ax0_2_ff, ay0_2_ff;
   logic [DIFF_BITS-1:0]        abs_x_2_ff, abs_y_2_ff;
   logic                        neg_x_2_ff, neg_y_2_ff;

   logic                        v3_ff;
   logic signed [NUM_BITS-1:0]  den_ff, tn_ff, un_ff;
   logic signed [CALC_BITS-1:0] ax0_3_ff, ay0_3_ff;
   logic [DIFF_BITS-1:0]        abs_x_3_ff, abs_y_3_ff;
   logic                        neg_x_3_ff, neg_y_3_ff;

   logic [DVD_BITS-1:0]         dvd_x_in, dvd_y_in;
   logic                        hit_in;
   div_type                     out_ff;

   assign ax0 = a_start_x[CALC_BITS-1:0];
   assign ay0 = a_start_y[CALC_BITS-1:0];
   assign ax1 = a_end_x[CALC_BITS-1:0];
   assign ay1 = a_end_y[CALC_BITS-1:0];
   assign bx0 = b_start_x[CALC_BITS-1:0];
   assign by0 = b_start_y[CALC_BITS-1:0];
   assign bx1 = b_end_x[CALC_BITS-1:0];
   assign by1 = b_end_y[CALC_BITS-1:0];

   always_comb begin
      hit_in = (den_ff > 0) && (tn_ff >= 0) && (tn_ff <= den_ff)
               && (un_ff >= 0) && (un_ff <= den_ff);
      dvd_x_in = DVD_BITS'(tn_ff[MAG_BITS-1:0]) * DVD_BITS'(abs_x_3_ff);
      dvd_y_in = DVD_BITS'(tn_ff[MAG_BITS-1:0]) * DVD_BITS'(abs_y_3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_ff.valid <= v3_ff;

         dax_ff   <= DIFF_BITS'(ax0) - DIFF_BITS'(ax1);
         day_ff   <= DIFF_BITS'(ay0) - DIFF_BITS'(ay1);
         dbx_ff   <= DIFF_BITS'(bx0) - DIFF_BITS'(bx1);
         dby_ff   <= DIFF_BITS'(by0) - DIFF_BITS'(by1);
         sx_ff    <= DIFF_BITS'(ax0) - DIFF_BITS'(bx0);
         sy_ff    <= DIFF_BITS'(ay0) - DIFF_BITS'(by0);
         ax0_1_ff <= ax0;
         ay0_1_ff <= ay0;

         p_den1_ff  <= PROD_BITS'(dax_ff) * PROD_BITS'(dby_ff);
         p_den2_ff  <= PROD_BITS'(day_ff) * PROD_BITS'(dbx_ff);
         p_tn1_ff   <= PROD_BITS'(sx_ff) * PROD_BITS'(dby_ff);
         p_tn2_ff   <= PROD_BITS'(sy_ff) * PROD_BITS'(dbx_ff);
         p_un1_ff   <= PROD_BITS'(day_ff) * PROD_BITS'(sx_ff);
         p_un2_ff   <= PROD_BITS'(dax_ff) * PROD_BITS'(sy_ff);
         ax0_2_ff   <= ax0_1_ff;
         ay0_2_ff   <= ay0_1_ff;
         abs_x_2_ff <= dax_ff[DIFF_BITS-1] ? DIFF_BITS'(-dax_ff) : DIFF_BITS'(dax_ff);
         abs_y_2_ff <= day_ff[DIFF_BITS-1] ? DIFF_BITS'(-day_ff) : DIFF_BITS'(day_ff);
         // The span end minus start is the negated difference.
         neg_x_2_ff <= (dax_ff > 0);
         neg_y_2_ff <= (day_ff > 0);

         den_ff     <= NUM_BITS'(p_den1_ff) - NUM_BITS'(p_den2_ff);
         tn_ff      <= NUM_BITS'(p_tn1_ff) - NUM_BITS'(p_tn2_ff);
         un_ff      <= NUM_BITS'(p_un1_ff) - NUM_BITS'(p_un2_ff);
         ax0_3_ff   <= ax0_2_ff;
         ay0_3_ff   <= ay0_2_ff;
         abs_x_3_ff <= abs_x_2_ff;
         abs_y_3_ff <= abs_y_2_ff;
         neg_x_3_ff <= neg_x_2_ff;
         neg_y_3_ff <= neg_y_2_ff;

         out_ff.hit   <= hit_in;
         out_ff.neg_x <= neg_x_3_ff;
         out_ff.neg_y <= neg_y_3_ff;
         out_ff.ax0   <= ax0_3_ff;
         out_ff.ay0   <= ay0_3_ff;
         out_ff.den   <= den_ff[MAG_BITS-1:0];
         out_ff.rem_x <= dvd_x_in[DVD_BITS-1:QUO_BITS];
         out_ff.rem_y <= dvd_y_in[DVD_BITS-1:QUO_BITS];
         out_ff.low_x <= dvd_x_in[QUO_BITS-1:0];
         out_ff.low_y <= dvd_y_in[QUO_BITS-1:0];
         out_ff.quo_x <= '0;
         out_ff.quo_y <= '0;
      end
   end

   assign out = out_ff;

endmodule

@@ rtl/segint_div_step.sv @@
// One registered restoring division step for both axes of the crossing point.
// Depends on segint_pkg; instantiated once per quotient bit by the top level.
module segint_div_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  segint_pkg::div_type in,
   output segint_pkg::div_type out
);
   import segint_pkg::*;

   logic [MAG_BITS:0] trial_x, trial_y, den_ext;
   logic              ge_x, ge_y;
   div_type           out_in, out_ff;

   always_comb begin
      den_ext = {1'b0, in.den};
      trial_x = {in.rem_x, in.low_x[QUO_BITS-1]};
      trial_y = {in.rem_y, in.low_y[QUO_BITS-1]};
      ge_x    = (trial_x >= den_ext);
      ge_y    = (trial_y >= den_ext);
      out_in  = in;
      out_in.rem_x = ge_x ? MAG_BITS'(trial_x - den_ext) : MAG_BITS'(trial_x);
      out_in.rem_y = ge_y ? MAG_BITS'(trial_y - den_ext) : MAG_BITS'(trial_y);
      out_in.low_x = {in.low_x[QUO_BITS-2:0], 1'b0};
      out_in.low_y = {in.low_y[QUO_BITS-2:0], 1'b0};
      out_in.quo_x = {in.quo_x[QUO_BITS-2:0], ge_x};
      out_in.quo_y = {in.quo_y[QUO_BITS-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule

@@ rtl/segment_intersection.sv @@
// Segment intersection block, top level.
// Depends on segint_pkg, segint_front and segint_div_step.
//
// Each transfer on the req_ channel carries two segments in signed Q12.4.
// Each transfer on the rsp_ channel returns rsp_hit and the crossing point,
// or zeros when the segments miss. Results come out in request order.
// The pipeline has four front stages, one divider stage per quotient bit and
// the output register. Throughput is one transfer per cycle while the
// pipeline is not held; the quotient bit chain of the divider sets the
// depth, one compare and subtract per stage.
// All stages move together. While rsp_valid is high and rsp_stall is high the
// whole pipeline holds and req_stall is raised, so nothing is lost or repeated.
// A new request is taken in the same cycle the waiting result leaves.
// Reset clears every valid bit together; no clearing pass is needed.
module segment_intersection (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_a_end_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_start_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_start_y,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_end_x,
   input  logic signed [segint_pkg::COORD_BITS-1:0] req_b_end_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_hit,
   output logic signed [segint_pkg::COORD_BITS-1:0] rsp_cross_x,
   output logic signed [segint_pkg::COORD_BITS-1:0] rsp_cross_y
);
   import segint_pkg::*;

   logic                         advance;
   div_type                      pipe [QUO_BITS+1];
   div_type                      last;
   logic signed [QUO_BITS:0]     quo_x, quo_y, off_x, off_y, sum_x, sum_y;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic signed [COORD_BITS-1:0] rsp_cross_x_ff, rsp_cross_y_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   segint_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .a_start_x (req_a_start_x),
      .a_start_y (req_a_start_y),
      .a_end_x   (req_a_end_x),
      .a_end_y   (req_a_end_y),
      .b_start_x (req_b_start_x),
      .b_start_y (req_b_start_y),
      .b_end_x   (req_b_end_x),
      .b_end_y   (req_b_end_y),
      .out       (pipe[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      segint_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .in      (pipe[i]),
         .out     (pipe[i+1])
      );
   end

   always_comb begin
      last  = pipe[QUO_BITS];
      quo_x = signed'({1'b0, last.quo_x});
      quo_y = signed'({1'b0, last.quo_y});
      off_x = last.neg_x ? -quo_x : quo_x;
      off_y = last.neg_y ? -quo_y : quo_y;
      sum_x = (QUO_BITS+1)'(last.ax0) + off_x;
      sum_y = (QUO_BITS+1)'(last.ay0) + off_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff     <= last.hit;
         rsp_cross_x_ff <= last.hit ? COORD_BITS'(sum_x) : '0;
         rsp_cross_y_ff <= last.hit ? COORD_BITS'(sum_y) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;

endmodule

@@ rtl/segint_check.sv @@
// Port-level checks for the segment intersection block, bound to the top level.
// Depends on segint_pkg and on the ports of segment_intersection.
module segint_check (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_stall,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic                                     rsp_hit,
   input logic signed [segint_pkg::COORD_BITS-1:0] rsp_cross_x,
   input logic signed [segint_pkg::COORD_BITS-1:0] rsp_cross_y
);

   // A reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Requests are held back exactly when a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the result stall");

   // A miss reports the origin.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss with a nonzero crossing point");

   // A stalled result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_cross_x) && $stable(rsp_cross_y)))
      else $error("stalled result changed");

endmodule

bind segment_intersection segint_check u_segint_check (.*);
